>>> src/clta_pkg.sv
// shared constants for the cluster link table allocator
`default_nettype none
package clta_pkg;

  localparam int unsigned LINK_ENTRIES_DEF     = 4096;
  localparam int unsigned LINKS_PER_SECTOR_DEF = 128;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned LINK_W    = 32;
  localparam int unsigned TOTAL_W   = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 48;

  localparam logic [OP_W-1:0] OP_FIND = 2'd0;
  localparam logic [OP_W-1:0] OP_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_GET  = 2'd2;
  // unused opcode, always answered with a failure
  localparam logic [OP_W-1:0] OP_BAD  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOUNTED = 1'd1;

  localparam logic [TOTAL_W-1:0] TOTAL_RST = 13'd4096;

  localparam logic [LINK_W-1:0] LINK_FREE = 32'h0000_0000;
  localparam logic [LINK_W-1:0] LINK_END  = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

>>> src/clta_div.sv
// serial restoring divider giving the remainder, one bit per cycle
`default_nettype none
module clta_div #(
  parameter int unsigned DW = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [DW-1:0] dvd_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] div_q;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DW-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    ge      = (rem_sh >= {1'b0, div_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      dvd_q <= {dvd_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

>>> src/cluster_link_table_allocator.sv
// top level: link table memory, next-fit free search, set and get of links
//
// The link table sits in one synchronous RAM of LINK_ENTRIES words. After reset
// a clearing pass writes every entry (entry 0 gets the end marker, the rest
// become free) in turn, and no item is accepted during that pass;
// configuration writes are taken at any time. The sector count comes from a
// reciprocal multiplication of the cluster count in the cycle after an item is
// taken. Set passes through a sector, an access and a done state; get adds a
// read state before done. Find first reduces the rover modulo the sector
// count with a serial divider (DW = clog2(LINK_ENTRIES + LINKS_PER_SECTOR),
// 13 at the defaults) and then reads one entry per cycle from the rover
// sector on, wrapping once, until it sees a free entry; when none is free it
// visits as many entries as the cluster count. Unmounted or unknown items go
// straight to the done state. The next item is taken while a result still
// waits on the output.
`default_nettype none
module cluster_link_table_allocator
  import clta_pkg::*;
#(
  parameter int unsigned LINK_ENTRIES     = LINK_ENTRIES_DEF,
  parameter int unsigned LINKS_PER_SECTOR = LINKS_PER_SECTOR_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // cfg
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  // items in
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // cluster_index[11:0], link_value[43:12], zero pad[47:44]
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  wire logic [OP_W-1:0]       s_axis_tuser,
  // items out
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // ok[0], found_index[12:1], link_data[44:13], zero pad[47:45]
  output logic [M_TDATA_W-1:0]       m_axis_tdata
);

  localparam int unsigned AW      = $clog2(LINK_ENTRIES);
  localparam int unsigned DW      = $clog2(LINK_ENTRIES + LINKS_PER_SECTOR);
  localparam int unsigned MAX_SEC = (LINK_ENTRIES + LINKS_PER_SECTOR - 1) / LINKS_PER_SECTOR;
  localparam int unsigned ROV_W   = (MAX_SEC > 1) ? $clog2(MAX_SEC) : 1;
  localparam int unsigned OFF_W   = $clog2(LINKS_PER_SECTOR);
  // reciprocal of the sector size, exact for every dividend below 2**DW
  localparam int unsigned RCP_S   = DW + OFF_W;
  localparam int unsigned RCP_W   = RCP_S + DW;
  localparam longint unsigned RCP_M = ((64'd1 << RCP_S) + 64'(LINKS_PER_SECTOR) - 64'd1) /
                                      64'(LINKS_PER_SECTOR);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEC  = 3'd1;
  localparam logic [2:0] ST_ROV  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_GET  = 3'd4;
  localparam logic [2:0] ST_SCAN = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // config registers
  logic [TOTAL_W-1:0] total_q;
  logic               mounted_q;

  // control
  logic [2:0]         state_q;
  logic               clr_q;
  logic [AW-1:0]      clr_addr_q;
  logic [ROV_W-1:0]   rover_q;

  // item
  logic [OP_W-1:0]    op_q;
  logic [IDX_W-1:0]   idx_q;
  logic [LINK_W-1:0]  val_q;
  logic [DW-1:0]      lim_q;

  // scan
  logic [AW-1:0]      p_q;
  logic [ROV_W-1:0]   p_sec_q;
  logic [OFF_W-1:0]   p_off_q;
  logic [DW-1:0]      iss_q;
  logic               rv_q;
  logic [AW-1:0]      ra_q;
  logic [ROV_W-1:0]   rsec_q;

  // pending result and output register
  logic               pend_ok_q;
  logic [IDX_W-1:0]   pend_found_q;
  logic [LINK_W-1:0]  pend_data_q;
  logic               m_valid_q;
  logic               m_ok_q;
  logic [IDX_W-1:0]   m_found_q;
  logic [LINK_W-1:0]  m_data_q;

  // memory
  logic [LINK_W-1:0]  mem [LINK_ENTRIES];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [LINK_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [LINK_W-1:0]  mem_rdata_q;

  // divider
  logic               div_start;
  logic [DW-1:0]      div_dvd;
  logic [DW-1:0]      div_dvs;
  logic               div_done;
  logic [DW-1:0]      div_rem;

  // sector count
  logic [DW-1:0]      sec_num;
  logic [RCP_W-1:0]   sec_prod;
  logic [DW-1:0]      sec_cnt;

  logic [DW-1:0]      used_w;
  logic               s_acc;
  logic               op_known;
  logic               idx_ok;
  logic               issue;
  logic               out_free;

  always_comb begin
    if (32'(total_q) > 32'(LINK_ENTRIES)) begin
      used_w = DW'(LINK_ENTRIES);
    end else begin
      used_w = DW'(total_q);
    end
  end

  // cluster count divided by the sector size, rounded up
  assign sec_num  = used_w + DW'(LINKS_PER_SECTOR - 1);
  assign sec_prod = RCP_W'(sec_num) * RCP_W'(RCP_M);
  assign sec_cnt  = sec_prod[RCP_S +: DW];

  assign s_axis_tready = (state_q == ST_IDLE) && !clr_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign op_known      = (s_axis_tuser == OP_FIND) || (s_axis_tuser == OP_SET) ||
                         (s_axis_tuser == OP_GET);
  // exclusive bound on the sector of the index
  assign idx_ok        = (32'(idx_q) < 32'(LINK_ENTRIES)) && (32'(idx_q) < 32'(lim_q));
  assign issue         = (state_q == ST_SCAN) && (iss_q != used_w);
  assign out_free      = !m_valid_q || m_axis_tready;

  // rover modulo the sector count
  assign div_start = (state_q == ST_SEC) && (op_q == OP_FIND) && (sec_cnt != '0);
  assign div_dvd   = DW'(rover_q);
  assign div_dvs   = sec_cnt;

  clta_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = (clr_addr_q == '0) ? LINK_END : LINK_FREE;
    mem_re    = 1'b0;
    mem_raddr = p_q;
    if (clr_q) begin
      mem_we = 1'b1;
    end else if ((state_q == ST_ACC) && idx_ok && (op_q == OP_SET)) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(idx_q);
      mem_wdata = val_q;
    end
    if ((state_q == ST_ACC) && (op_q == OP_GET)) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(idx_q);
    end else if (issue) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= TOTAL_RST;
      mounted_q    <= 1'b0;
      state_q      <= ST_IDLE;
      clr_q        <= 1'b1;
      clr_addr_q   <= '0;
      rover_q      <= '0;
      op_q         <= OP_FIND;
      idx_q        <= '0;
      val_q        <= '0;
      lim_q        <= '0;
      p_q          <= '0;
      p_sec_q      <= '0;
      p_off_q      <= '0;
      iss_q        <= '0;
      rv_q         <= 1'b0;
      ra_q         <= '0;
      rsec_q       <= '0;
      pend_ok_q    <= 1'b0;
      pend_found_q <= '0;
      pend_data_q  <= '0;
      m_valid_q    <= 1'b0;
      m_ok_q       <= 1'b0;
      m_found_q    <= '0;
      m_data_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TOTAL:   total_q   <= cfg_data_i[TOTAL_W-1:0];
          CFG_MOUNTED: mounted_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (clr_q) begin
        if (clr_addr_q == AW'(LINK_ENTRIES - 1)) begin
          clr_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + AW'(1);
        end
      end

      if ((state_q == ST_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            op_q         <= s_axis_tuser;
            idx_q        <= s_axis_tdata[IDX_W-1:0];
            val_q        <= s_axis_tdata[IDX_W +: LINK_W];
            pend_ok_q    <= 1'b0;
            pend_found_q <= '0;
            pend_data_q  <= '0;
            state_q      <= (mounted_q && op_known) ? ST_SEC : ST_DONE;
          end
        end
        ST_SEC: begin
          lim_q <= DW'(32'(sec_cnt) * 32'(LINKS_PER_SECTOR));
          if (op_q != OP_FIND) begin
            state_q <= ST_ACC;
          end else if (sec_cnt == '0) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_ROV;
          end
        end
        ST_ROV: begin
          if (div_done) begin
            p_q     <= AW'(32'(div_rem[ROV_W-1:0]) * 32'(LINKS_PER_SECTOR));
            p_sec_q <= div_rem[ROV_W-1:0];
            p_off_q <= '0;
            iss_q   <= '0;
            rv_q    <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_ACC: begin
          if (!idx_ok) begin
            state_q <= ST_DONE;
          end else if (op_q == OP_SET) begin
            pend_ok_q <= 1'b1;
            state_q   <= ST_DONE;
          end else begin
            state_q <= ST_GET;
          end
        end
        ST_GET: begin
          pend_ok_q   <= 1'b1;
          pend_data_q <= mem_rdata_q;
          state_q     <= ST_DONE;
        end
        ST_SCAN: begin
          rv_q   <= issue;
          ra_q   <= p_q;
          rsec_q <= p_sec_q;
          if (issue) begin
            iss_q <= iss_q + DW'(1);
            // wrap to entry 0 after the last entry in use
            if (DW'(p_q) == used_w - DW'(1)) begin
              p_q     <= '0;
              p_sec_q <= '0;
              p_off_q <= '0;
            end else begin
              p_q <= p_q + AW'(1);
              if (p_off_q == OFF_W'(LINKS_PER_SECTOR - 1)) begin
                p_off_q <= '0;
                p_sec_q <= p_sec_q + ROV_W'(1);
              end else begin
                p_off_q <= p_off_q + OFF_W'(1);
              end
            end
          end
          if (rv_q && (mem_rdata_q == LINK_FREE)) begin
            rover_q      <= rsec_q;
            pend_ok_q    <= 1'b1;
            pend_found_q <= IDX_W'(ra_q);
            state_q      <= ST_DONE;
          end else if (!rv_q && !issue) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_ok_q    <= pend_ok_q;
            m_found_q <= pend_found_q;
            m_data_q  <= pend_data_q;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - 1 - IDX_W - LINK_W)'(0), m_data_q, m_found_q, m_ok_q};

endmodule
`default_nettype wire

>>> tb/clta_link_checker.sv
// checker for the link table allocator: predicts every answer and compares it
`timescale 1ns / 100ps
module clta_link_checker
  import clta_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 s_tvalid_i,
  input  wire logic                 s_tready_i,
  input  wire logic [S_TDATA_W-1:0] s_tdata_i,
  input  wire logic [OP_W-1:0]      s_tuser_i,
  input  wire logic                 m_tvalid_i,
  input  wire logic                 m_tready_i,
  input  wire logic [M_TDATA_W-1:0] m_tdata_i,
  output int unsigned               outstanding_o,
  output int unsigned               errors_o
);

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  found;
    logic [LINK_W-1:0] data;
  } link_answer_t;

  logic [LINK_W-1:0]  links [LINK_ENTRIES_DEF];
  int unsigned        rover;
  logic [TOTAL_W-1:0] cluster_total;
  logic               mounted;
  link_answer_t       answers_due [$];
  link_answer_t       predicted;
  link_answer_t       oldest;
  link_answer_t       seen;
  int unsigned        err_cnt = 0;

  // next-fit search, set and get against the shadow table
  task automatic apply_link_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                               input logic [LINK_W-1:0] val, output link_answer_t ans);
    int unsigned used, sectors, start, sec, cnt, pos, i, j;
    bit hit;
    ans = '0;
    hit = 1'b0;
    used = (cluster_total > LINK_ENTRIES_DEF) ? LINK_ENTRIES_DEF : cluster_total;
    sectors = (used + LINKS_PER_SECTOR_DEF - 1) / LINKS_PER_SECTOR_DEF;
    if (mounted) begin
      case (op)
        OP_FIND: begin
          if (sectors != 0) begin
            start = rover % sectors;
            for (i = 0; i < sectors && !hit; i++) begin
              sec = (start + i) % sectors;
              cnt = LINKS_PER_SECTOR_DEF;
              // a partly used last sector is searched only up to the cluster count
              if (sec == sectors - 1 && (used % LINKS_PER_SECTOR_DEF) != 0)
                cnt = used % LINKS_PER_SECTOR_DEF;
              for (j = 0; j < cnt && !hit; j++) begin
                pos = sec * LINKS_PER_SECTOR_DEF + j;
                if (pos < LINK_ENTRIES_DEF && links[pos] == LINK_FREE) begin
                  hit = 1'b1;
                  rover = sec;
                  ans.ok = 1'b1;
                  ans.found = pos[IDX_W-1:0];
                end
              end
            end
          end
        end
        OP_SET: begin
          if (idx / LINKS_PER_SECTOR_DEF < sectors) begin
            links[idx] = val;
            ans.ok = 1'b1;
          end
        end
        OP_GET: begin
          if (idx / LINKS_PER_SECTOR_DEF < sectors) begin
            ans.data = links[idx];
            ans.ok = 1'b1;
          end
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LINK_ENTRIES_DEF; k++) links[k] = LINK_FREE;
      links[0] = LINK_END;
      rover = 0;
      cluster_total = TOTAL_RST;
      mounted = 1'b0;
      answers_due.delete();
      outstanding_o <= 0;
      errors_o <= err_cnt;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TOTAL) cluster_total = cfg_data_i[TOTAL_W-1:0];
        else if (cfg_idx_i == CFG_MOUNTED) mounted = cfg_data_i[0];
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_link_op(s_tuser_i, s_tdata_i[IDX_W-1:0], s_tdata_i[IDX_W +: LINK_W], predicted);
        answers_due.push_back(predicted);
      end
      if (m_tvalid_i && m_tready_i) begin
        seen.ok = m_tdata_i[0];
        seen.found = m_tdata_i[1 +: IDX_W];
        seen.data = m_tdata_i[1 + IDX_W +: LINK_W];
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected item: ok=%0d found=%0d data=%h", $time,
                   seen.ok, seen.found, seen.data);
          err_cnt++;
        end else begin
          oldest = answers_due.pop_front();
          if (seen.ok !== oldest.ok) begin
            $display("%0t: ok expected %0d actual %0d", $time, oldest.ok, seen.ok);
            err_cnt++;
          end
          if (seen.found !== oldest.found) begin
            $display("%0t: found_index expected %0d actual %0d", $time,
                     oldest.found, seen.found);
            err_cnt++;
          end
          if (seen.data !== oldest.data) begin
            $display("%0t: link_data expected %h actual %h", $time, oldest.data, seen.data);
            err_cnt++;
          end
        end
      end
      outstanding_o <= answers_due.size();
      errors_o <= err_cnt;
    end
  end

endmodule

>>> tb/cluster_link_table_allocator_tb.sv
// testbench top: stimulus, flow control and verdict for the link table allocator
`timescale 1ns / 100ps
module cluster_link_table_allocator_tb;
  import clta_pkg::*;

  localparam int unsigned QUIET_LIMIT = 30000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // cluster_index[11:0], link_value[43:12], zero pad[47:44]
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // opcode[1:0]
  logic [OP_W-1:0]      s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // ok[0], found_index[12:1], link_data[44:13], zero pad[47:45]
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int unsigned outstanding;
  int unsigned errors;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned cur_total = TOTAL_RST;
  int unsigned cursor = 1;
  bit          tx_gappy = 1'b1;
  bit          rx_gappy = 1'b1;

  cluster_link_table_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  clta_link_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  always #2 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_gappy && $urandom_range(0, 99) < 30) begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [LINK_W-1:0] val);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(S_TDATA_W - IDX_W - LINK_W){1'b0}}, val, idx};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = tx_gappy ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the sender until every answer is back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(input int unsigned total, input bit mnt);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_TOTAL;
    cfg_data_i <= total[CFG_W-1:0];
    @(posedge clk_i);
    cfg_idx_i <= CFG_MOUNTED;
    cfg_data_i <= {{(CFG_W-1){1'b0}}, mnt};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_total = total;
  endtask

  // allocation-like traffic: a cursor walks up the table writing chain links,
  // mixed with searches, reads, frees and raw noise
  task automatic random_item(input int unsigned fill_pct);
    int unsigned eff, r, pick;
    logic [LINK_W-1:0] val;
    eff = (cur_total > LINK_ENTRIES_DEF) ? LINK_ENTRIES_DEF : cur_total;
    r = $urandom_range(0, 99);
    if (eff != 0 && r < fill_pct) begin
      cursor = cursor % eff;
      pick = $urandom_range(0, 2);
      if (pick == 0) val = cursor + 1;
      else if (pick == 1) val = LINK_END;
      else val = $urandom() | 32'h1;
      send_item(OP_SET, cursor[IDX_W-1:0], val);
      cursor = (cursor + 1) % eff;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_item(OP_FIND, IDX_W'($urandom()), $urandom());
      else if (pick < 70)
        send_item(OP_GET, IDX_W'((eff != 0) ? $urandom_range(0, eff - 1) : $urandom()),
                  $urandom());
      else if (pick < 85)
        send_item(OP_SET, IDX_W'((eff != 0) ? $urandom_range(0, eff - 1) : $urandom()),
                  LINK_FREE);
      else
        send_item(OP_W'($urandom_range(0, 3)), IDX_W'($urandom()), $urandom());
    end
  endtask

  task automatic run_phase(input int unsigned total, input bit mnt, input int unsigned items,
                           input int unsigned fill_pct, input int unsigned mode);
    set_mode(total, mnt);
    tx_gappy = (mode != 1);
    rx_gappy = (mode != 2);
    repeat (items) random_item(fill_pct);
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TOTAL;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_FIND;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unmounted after reset: everything fails
    send_item(OP_FIND, 12'd0, 32'd0);
    send_item(OP_SET, 12'd5, 32'h1234_5678);
    send_item(OP_GET, 12'd5, 32'd0);
    send_item(OP_BAD, 12'd0, 32'd0);
    wait_idle();

    // cluster count above the table size saturates
    set_mode(8191, 1'b1);
    send_item(OP_FIND, 12'd0, 32'd0);
    send_item(OP_GET, 12'd0, 32'd0);
    send_item(OP_SET, 12'd4095, 32'hFFFF_FFFF);
    send_item(OP_GET, 12'd4095, 32'd0);
    send_item(OP_SET, 12'd1, 32'h0000_0001);
    send_item(OP_FIND, 12'd0, 32'd0);
    send_item(OP_SET, 12'd0, LINK_FREE);
    send_item(OP_FIND, 12'd0, 32'd0);
    send_item(OP_BAD, 12'd4095, 32'hFFFF_FFFF);
    send_item(OP_SET, 12'd0, LINK_END);
    wait_idle();

    // single cluster holding the end marker: nothing free, small bound
    set_mode(1, 1'b1);
    send_item(OP_FIND, 12'd0, 32'd0);
    send_item(OP_GET, 12'd127, 32'd0);
    send_item(OP_GET, 12'd128, 32'd0);
    send_item(OP_SET, 12'd200, 32'hDEAD_BEEF);
    wait_idle();

    // no sectors at all
    set_mode(0, 1'b1);
    send_item(OP_FIND, 12'd0, 32'd0);
    send_item(OP_GET, 12'd0, 32'd0);
    send_item(OP_SET, 12'd0, 32'h5555_5555);
    wait_idle();

    set_mode(4096, 1'b1);
    send_item(OP_GET, 12'd4095, 32'd0);
    send_item(OP_SET, 12'd4095, LINK_FREE);
    send_item(OP_SET, 12'd2, 32'h8000_0000);
    wait_idle();

    // fill sector 0 so the search moves on, then shrink below the rover
    run_phase($urandom_range(129, 200), 1'b1, 220, 70, 0);
    run_phase($urandom_range(1, 128), 1'b1, 80, 50, 1);
    run_phase(4096, 1'b0, 30, 35, 2);
    run_phase(4096, 1'b1, 100, 35, 0);
    run_phase(8191, 1'b1, 80, 35, 1);
    run_phase(0, 1'b1, 30, 35, 0);
    run_phase(128, 1'b1, 100, 50, 2);
    run_phase($urandom_range(256, 2000), 1'b1, 100, 40, 0);
    run_phase($urandom_range(2, 127), 1'b1, 80, 50, 1);

    repeat (40) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
